/* sv/bnlj_pkg.sv */
// Shared types, constants and helpers for the block nested-loop equi-join core.
// No dependencies.
package bnlj_pkg;

	localparam int OUTER_SLOTS = 64;
	localparam int MAX_ARITY   = 4;
	localparam int ATTR_W      = 32;
	localparam int SLOT_W      = 6;
	localparam int CNT_W       = 7;
	localparam int MERGED_N    = 8;

	typedef logic [3:0][ATTR_W-1:0] tuple_t;
	typedef logic [MERGED_N-1:0][ATTR_W-1:0] merged_t;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_PROBE = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_OUTER_KEY   = 3'd0,
		REG_INNER_KEY   = 3'd1,
		REG_OUTER_ARITY = 3'd2,
		REG_INNER_ARITY = 3'd3,
		REG_OUTER_FIRST = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	function automatic logic [2:0] eff_arity(input logic [2:0] a);
		if (a == 3'd0) return 3'd1;
		if (a > 3'(MAX_ARITY)) return 3'(MAX_ARITY);
		return a;
	endfunction

	function automatic logic [ATTR_W-1:0] attr_at(input tuple_t t, input logic [1:0] col,
		input logic [2:0] ar);
		if (ar > {1'b0, col}) return t[col];
		return '0;
	endfunction

endpackage

/* sv/bnlj_cell.sv */
// One outer block slot: holds a tuple, loads it directly, passes it on in the ring.
// Depends on bnlj_pkg.
module bnlj_cell import bnlj_pkg::*; (
	input  logic   clk,
	input  logic   load_en,
	input  tuple_t load_tuple,
	input  logic   shift_en,
	input  tuple_t prev_tuple,
	output tuple_t tuple
);

	tuple_t tuple_q;

	always_ff @(posedge clk) begin
		if (load_en) begin
			tuple_q <= load_tuple;
		end else if (shift_en) begin
			tuple_q <= prev_tuple;
		end
	end

	assign tuple = tuple_q;

endmodule

/* sv/bnlj_merge.sv */
// Builds the merged result tuple from an outer and an inner tuple.
// Depends on bnlj_pkg.
module bnlj_merge import bnlj_pkg::*; (
	input  tuple_t      outer_tuple,
	input  tuple_t      inner_tuple,
	input  logic [2:0]  outer_arity,
	input  logic [2:0]  inner_arity,
	input  logic        outer_first,
	output merged_t     merged
);

	tuple_t     first_t;
	tuple_t     second_t;
	logic [2:0] fa;
	logic [2:0] sa;

	assign first_t  = outer_first ? outer_tuple : inner_tuple;
	assign second_t = outer_first ? inner_tuple : outer_tuple;
	assign fa       = outer_first ? outer_arity : inner_arity;
	assign sa       = outer_first ? inner_arity : outer_arity;

	always_comb begin
		logic [3:0] kk;
		logic [3:0] idx;
		for (int k = 0; k < MERGED_N; k++) begin
			kk  = 4'(k);
			idx = kk - {1'b0, fa};
			if (kk < {1'b0, fa}) begin
				merged[k] = first_t[kk[1:0]];
			end else if (idx < {1'b0, sa}) begin
				merged[k] = second_t[idx[1:0]];
			end else begin
				merged[k] = '0;
			end
		end
	end

endmodule

/* sv/block_nested_loop_equi_join_core.sv */
// Block nested-loop equi-join core: a ring of 64 tuple cells scanned by a probe.
// Depends on bnlj_pkg, bnlj_cell, bnlj_merge.
//
// Load and clear items are accepted only while idle. A probe rotates the whole
// 64-cell ring once past the compare point at cell 0, one slot per cycle unless
// a held match waits on a stalled output, and then releases the held last match
// in a flush state. Matches leave in slot order; each is held back one match so
// the final one can carry tlast. Loads past 64 slots are dropped. Configuration
// writes are not blocked; write registers only while no probe is running and no
// match is waiting.
module block_nested_loop_equi_join_core import bnlj_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // attr0, attr1, attr2, attr3
	input  logic [1:0]   s_axis_tuser,  // operation
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [263:0] m_axis_tdata,  // joined_pair01, 23, 45, 67, matched_slot, pad
	output logic         m_axis_tlast,  // last_match
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [2:0]   cfg_data
);

	logic [1:0] okc_q, ikc_q;
	logic [2:0] oar_q, iar_q;
	logic       ofirst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			okc_q    <= '0;
			ikc_q    <= '0;
			oar_q    <= 3'd4;
			iar_q    <= 3'd4;
			ofirst_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OUTER_KEY:   okc_q    <= cfg_data[1:0];
				REG_INNER_KEY:   ikc_q    <= cfg_data[1:0];
				REG_OUTER_ARITY: oar_q    <= cfg_data;
				REG_INNER_ARITY: iar_q    <= cfg_data;
				REG_OUTER_FIRST: ofirst_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	state_t          state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [SLOT_W-1:0] scan_q;
	tuple_t          inner_q;
	logic [ATTR_W-1:0] ikey_q;

	logic   in_acc;
	op_t    op;
	tuple_t in_tuple;
	logic [2:0] oa_eff, ia_eff;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign op       = op_t'(s_axis_tuser);
	assign in_tuple = s_axis_tdata;
	assign oa_eff   = eff_arity(oar_q);
	assign ia_eff   = eff_arity(iar_q);

	// cell ring
	tuple_t cell_t [OUTER_SLOTS];
	logic   do_load;
	logic   step;

	assign do_load = in_acc && (op == OP_LOAD) && (count_q < CNT_W'(OUTER_SLOTS));

	for (genvar g = 0; g < OUTER_SLOTS; g++) begin : g_cell
		bnlj_cell u_cell (
			.clk        (clk),
			.load_en    (do_load && (count_q[SLOT_W-1:0] == SLOT_W'(g))),
			.load_tuple (in_tuple),
			.shift_en   (step),
			.prev_tuple (cell_t[(g + 1) % OUTER_SLOTS]),
			.tuple      (cell_t[g])
		);
	end

	merged_t merged;

	bnlj_merge u_merge (
		.outer_tuple (cell_t[0]),
		.inner_tuple (inner_q),
		.outer_arity (oa_eff),
		.inner_arity (ia_eff),
		.outer_first (ofirst_q),
		.merged      (merged)
	);

	logic hit;
	assign hit = ({1'b0, scan_q} < count_q) && (attr_at(cell_t[0], okc_q, oa_eff) == ikey_q);

	// held match and output register
	logic              pend_v_q;
	merged_t           pend_m_q;
	logic [SLOT_W-1:0] pend_s_q;
	logic              out_v_q;
	merged_t           out_m_q;
	logic [SLOT_W-1:0] out_s_q;
	logic              out_l_q;
	logic              out_free;
	logic              push_out;
	logic              push_last;
	logic              take_pend;

	assign out_free = !out_v_q || m_axis_tready;

	always_comb begin
		state_d   = state_q;
		step      = 1'b0;
		push_out  = 1'b0;
		push_last = 1'b0;
		take_pend = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && op == OP_PROBE) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (!hit || !pend_v_q || out_free) begin
					step      = 1'b1;
					take_pend = hit;
					push_out  = hit && pend_v_q;
					if (scan_q == SLOT_W'(OUTER_SLOTS - 1)) state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (!pend_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					push_out  = 1'b1;
					push_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			scan_q   <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_load) count_q <= count_q + 1'b1;
			else if (in_acc && op == OP_CLEAR) count_q <= '0;
			if (in_acc) scan_q <= '0;
			else if (step) scan_q <= scan_q + 1'b1;
			if (take_pend) pend_v_q <= 1'b1;
			else if (push_out) pend_v_q <= 1'b0;
			if (push_out) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			inner_q <= in_tuple;
			ikey_q  <= attr_at(in_tuple, ikc_q, ia_eff);
		end
		if (take_pend) begin
			pend_m_q <= merged;
			pend_s_q <= scan_q;
		end
		if (push_out) begin
			out_m_q <= pend_m_q;
			out_s_q <= pend_s_q;
			out_l_q <= push_last;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {2'b00, out_s_q, out_m_q};
	assign m_axis_tlast  = out_l_q;

endmodule
